// ===== rtl/core/rpa_pkg.sv =====
`default_nettype none
package rpa_pkg;

  localparam int unsigned GAIN_FRAC_BITS = 8;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_MONO_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_ENABLE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST_GAIN     = 3'd3;

  localparam logic [10:0] GAIN_RESET = 11'd256;

  localparam logic [15:0] LUM_WR = 16'd19595;
  localparam logic [15:0] LUM_WG = 16'd38470;
  localparam logic [15:0] LUM_WB = 16'd7471;

  typedef logic [23:0] lum_prod_t;
  typedef logic signed [9:0] chan_sum_t;
  typedef logic [19:0] gain_prod_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } rpa_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } rpa_out_t;

  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } rpa_adv_t;

endpackage
`default_nettype wire

// ===== rtl/core/rpa_front.sv =====
`default_nettype none
module rpa_front
  import rpa_pkg::*;
(
  input  wire logic         clk,
  input  wire rpa_adv_t     adv,
  input  wire rpa_in_t      pix,
  input  wire logic         mono_enable,
  input  wire logic         invert_enable,
  input  wire logic [8:0]   brightness_offset,
  output chan_sum_t         sum_red,
  output chan_sum_t         sum_green,
  output chan_sum_t         sum_blue
);

  lum_prod_t pr_r, pg_r, pb_r;
  rpa_in_t   pix_r;
  chan_sum_t sr_r, sg_r, sb_r;
  chan_sum_t sr_nxt, sg_nxt, sb_nxt;
  lum_prod_t lum_sum;
  logic [7:0] lum;
  logic [7:0] vr, vg, vb;
  logic signed [9:0] bright_ext;

  // stage 1: luminance partial products
  always_ff @(posedge clk) begin
    if (adv.ld1) begin
      pr_r  <= lum_prod_t'(LUM_WR) * lum_prod_t'(pix.red_in);
      pg_r  <= lum_prod_t'(LUM_WG) * lum_prod_t'(pix.green_in);
      pb_r  <= lum_prod_t'(LUM_WB) * lum_prod_t'(pix.blue_in);
      pix_r <= pix;
    end
  end

  // stage 2: mono select, invert, brightness
  always_comb begin
    lum_sum    = pr_r + pg_r + pb_r;
    lum        = lum_sum[23:16];
    vr         = mono_enable ? lum : pix_r.red_in;
    vg         = mono_enable ? lum : pix_r.green_in;
    vb         = mono_enable ? lum : pix_r.blue_in;
    if (invert_enable) begin
      vr = ~vr;
      vg = ~vg;
      vb = ~vb;
    end
    bright_ext = $signed({brightness_offset[8], brightness_offset});
    sr_nxt     = $signed({2'b00, vr}) + bright_ext;
    sg_nxt     = $signed({2'b00, vg}) + bright_ext;
    sb_nxt     = $signed({2'b00, vb}) + bright_ext;
  end

  always_ff @(posedge clk) begin
    if (adv.ld2) begin
      sr_r <= sr_nxt;
      sg_r <= sg_nxt;
      sb_r <= sb_nxt;
    end
  end

  assign sum_red   = sr_r;
  assign sum_green = sg_r;
  assign sum_blue  = sb_r;

endmodule
`default_nettype wire

// ===== rtl/core/rpa_gain.sv =====
`default_nettype none
module rpa_gain
  import rpa_pkg::*;
(
  input  wire logic       clk,
  input  wire rpa_adv_t   adv,
  input  wire chan_sum_t  chan_sum,
  input  wire logic [10:0] contrast_gain,
  output logic [7:0]      chan_out
);

  gain_prod_t prod_r;
  logic       pos_r;
  logic [7:0] chan_r;
  logic [7:0] chan_nxt;
  gain_prod_t scaled;

  // stage 3: contrast multiply
  always_ff @(posedge clk) begin
    if (adv.ld3) begin
      prod_r <= gain_prod_t'(chan_sum[8:0]) * gain_prod_t'(contrast_gain);
      pos_r  <= (chan_sum > 10'sd0);
    end
  end

  // stage 4: drop fraction bits and clamp
  always_comb begin
    scaled = prod_r >> GAIN_FRAC_BITS;
    if (!pos_r) begin
      chan_nxt = 8'd0;
    end else if (scaled > gain_prod_t'(255)) begin
      chan_nxt = 8'hFF;
    end else begin
      chan_nxt = scaled[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.ld4) begin
      chan_r <= chan_nxt;
    end
  end

  assign chan_out = chan_r;

endmodule
`default_nettype wire

// ===== rtl/core/rgb_pixel_adjust_unit.sv =====
// throughput: one item per cycle while out_stall is low, set by the four-stage pipeline
// (luma products, mono/invert/brightness, contrast multiply, clamp)
// reset: synchronous active-low rst_n empties the pipeline and sets
// mono and invert off, brightness 0 and contrast gain 1.0
`default_nettype none
module rgb_pixel_adjust_unit
  import rpa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire rpa_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output rpa_out_t                   out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic        mono_r, invert_r;
  logic [8:0]  bright_r;
  logic [10:0] gain_r;
  logic        v1_r, v2_r, v3_r, v4_r;
  logic        rdy1, rdy2, rdy3, rdy4;
  rpa_adv_t    adv;
  chan_sum_t   sum_red, sum_green, sum_blue;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mono_r   <= 1'b0;
      invert_r <= 1'b0;
      bright_r <= 9'd0;
      gain_r   <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MONO_ENABLE:       mono_r   <= cfg_data[0];
        CFG_INVERT_ENABLE:     invert_r <= cfg_data[0];
        CFG_BRIGHTNESS_OFFSET: bright_r <= cfg_data[8:0];
        CFG_CONTRAST_GAIN:     gain_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign rdy4 = !v4_r || !out_stall;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign adv.ld1 = rdy1;
  assign adv.ld2 = rdy2;
  assign adv.ld3 = rdy3;
  assign adv.ld4 = rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  assign in_stall  = !rdy1;
  assign out_valid = v4_r;

  rpa_front u_front (
    .clk               (clk),
    .adv               (adv),
    .pix               (in_data),
    .mono_enable       (mono_r),
    .invert_enable     (invert_r),
    .brightness_offset (bright_r),
    .sum_red           (sum_red),
    .sum_green         (sum_green),
    .sum_blue          (sum_blue)
  );

  rpa_gain u_gain_red (
    .clk           (clk),
    .adv           (adv),
    .chan_sum      (sum_red),
    .contrast_gain (gain_r),
    .chan_out      (out_data.red_out)
  );

  rpa_gain u_gain_green (
    .clk           (clk),
    .adv           (adv),
    .chan_sum      (sum_green),
    .contrast_gain (gain_r),
    .chan_out      (out_data.green_out)
  );

  rpa_gain u_gain_blue (
    .clk           (clk),
    .adv           (adv),
    .chan_sum      (sum_blue),
    .contrast_gain (gain_r),
    .chan_out      (out_data.blue_out)
  );

endmodule
`default_nettype wire

// ===== bench/rgb_pixel_adjust_unit_test.sv =====
`timescale 1ns / 100ps

module rgb_pixel_adjust_unit_test
  import rpa_pkg::*;
();

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 11;
  localparam int PIPE_LAT = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AT = 150;
  localparam int HOLD_LEN = 64;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 80;
  localparam int MAX_SHOWN = 10;
  localparam int GAIN_SHIFT = 8;
  localparam int LUMA_R = 19595;
  localparam int LUMA_G = 38470;
  localparam int LUMA_B = 7471;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    rpa_in_t               px;
    bit                    typed;
    rpa_out_t              want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  rpa_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  rpa_out_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit                    mono_on;
  bit                    invert_on;
  logic signed [8:0]     bright_ofs;
  logic [10:0]           gain_q8;
  rpa_out_t              expected_pixels[$];
  plan_row_t             plan[$];
  int                    mismatches = 0;
  int                    results_seen = 0;
  int                    cycle_count = 0;
  bit                    no_idle = 1'b0;

  rgb_pixel_adjust_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic logic [7:0] adjusted_channel(logic [7:0] v);
    int s;
    int prod;
    if (invert_on) begin
      v = 8'd255 - v;
    end
    s = int'(v) + int'(bright_ofs);
    if (s <= 0) begin
      return 8'd0;
    end
    prod = (s * int'(gain_q8)) >> GAIN_SHIFT;
    return (prod > 255) ? 8'd255 : 8'(prod);
  endfunction

  function automatic rpa_out_t adjusted_pixel(rpa_in_t px);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    int luma;
    rpa_out_t res;
    r = px.red_in;
    g = px.green_in;
    b = px.blue_in;
    if (mono_on) begin
      luma = (LUMA_R * int'(r) + LUMA_G * int'(g) + LUMA_B * int'(b)) >> 16;
      if (luma > 255) begin
        luma = 255;
      end
      r = 8'(luma);
      g = 8'(luma);
      b = 8'(luma);
    end
    res.red_out = adjusted_channel(r);
    res.green_out = adjusted_channel(g);
    res.blue_out = adjusted_channel(b);
    return res;
  endfunction

  function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.val = val;
    row.px = '0;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic plan_row_t pixel_row(logic [23:0] px, bit typed, logic [23:0] want);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.idx = '0;
    row.val = '0;
    row.px = rpa_in_t'(px);
    row.typed = typed;
    row.want = rpa_out_t'(want);
    return row;
  endfunction

  task automatic record_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_MONO_ENABLE: begin
        mono_on = val[0];
      end
      CFG_INVERT_ENABLE: begin
        invert_on = val[0];
      end
      CFG_BRIGHTNESS_OFFSET: begin
        bright_ofs = val[8:0];
      end
      CFG_CONTRAST_GAIN: begin
        gain_q8 = val[10:0];
      end
      default: begin
      end
    endcase
  endtask

  // leaves cfg_valid high; the next pixel lowers it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    record_config(idx, val);
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic send_pixel(rpa_in_t px, bit typed, rpa_out_t want);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (in_stall);
    expected_pixels.push_back(typed ? want : adjusted_pixel(px));
  endtask

  task automatic check_pixel(rpa_out_t got);
    rpa_out_t want;
    results_seen++;
    if (expected_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN) begin
        $display("unexpected pixel r=%h g=%h b=%h", got.red_out, got.green_out, got.blue_out);
      end
    end else begin
      want = expected_pixels.pop_front();
      if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
          got.blue_out !== want.blue_out) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("pixel %0d: expected r=%h g=%h b=%h, got r=%h g=%h b=%h", results_seen,
                   want.red_out, want.green_out, want.blue_out,
                   got.red_out, got.green_out, got.blue_out);
        end
      end
    end
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int hold;
    bit held;
    held = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held && results_seen >= HOLD_AT) begin
        hold = HOLD_LEN;
        held = 1'b1;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      check_pixel(out_data);
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] bright_marks[4];
    logic [CFG_DATA_W-1:0] gain_marks[4];
    logic [CFG_DATA_W-1:0] pick;
    logic [23:0] bits;
    rpa_in_t px;
    bit was_pixel;

    bright_marks = '{11'h0FF, 11'h101, 11'h100, 11'h000};
    gain_marks = '{11'd0, 11'd26, 11'd1280, 11'd2047};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mono_on = 1'b0;
    invert_on = 1'b0;
    bright_ofs = '0;
    gain_q8 = GAIN_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    plan.push_back(pixel_row(24'h000000, 1'b1, 24'h000000));
    plan.push_back(pixel_row(24'hFFFFFF, 1'b1, 24'hFFFFFF));
    plan.push_back(pixel_row(24'h123456, 1'b1, 24'h123456));
    plan.push_back(pixel_row(24'h8001FE, 1'b1, 24'h8001FE));
    plan.push_back(cfg_row(CFG_INVERT_ENABLE, 11'd1));
    plan.push_back(pixel_row(24'h00FF10, 1'b1, 24'hFF00EF));
    plan.push_back(pixel_row(24'h7F803C, 1'b1, 24'h807FC3));
    plan.push_back(cfg_row(CFG_INVERT_ENABLE, 11'd0));
    plan.push_back(cfg_row(CFG_MONO_ENABLE, 11'd1));
    plan.push_back(pixel_row(24'hFFFFFF, 1'b1, 24'hFFFFFF));
    plan.push_back(pixel_row(24'hFF0000, 1'b0, 24'h0));
    plan.push_back(pixel_row(24'h00FF00, 1'b0, 24'h0));
    plan.push_back(pixel_row(24'h0000FF, 1'b0, 24'h0));
    plan.push_back(cfg_row(CFG_MONO_ENABLE, 11'd0));
    plan.push_back(cfg_row(CFG_BRIGHTNESS_OFFSET, 11'h0FF));
    plan.push_back(pixel_row(24'h000000, 1'b1, 24'hFFFFFF));
    plan.push_back(pixel_row(24'h0180FF, 1'b1, 24'hFFFFFF));
    plan.push_back(cfg_row(CFG_BRIGHTNESS_OFFSET, 11'h101));
    plan.push_back(pixel_row(24'hFFFE00, 1'b1, 24'h000000));
    plan.push_back(cfg_row(CFG_BRIGHTNESS_OFFSET, 11'h100));
    plan.push_back(pixel_row(24'hFFFFFF, 1'b1, 24'h000000));
    plan.push_back(cfg_row(CFG_BRIGHTNESS_OFFSET, 11'h1FF));
    plan.push_back(pixel_row(24'h010200, 1'b1, 24'h000100));
    plan.push_back(cfg_row(CFG_BRIGHTNESS_OFFSET, 11'h000));
    plan.push_back(cfg_row(CFG_CONTRAST_GAIN, 11'd0));
    plan.push_back(pixel_row(24'hFFFFFF, 1'b1, 24'h000000));
    plan.push_back(cfg_row(CFG_CONTRAST_GAIN, 11'd2047));
    plan.push_back(pixel_row(24'h010002, 1'b1, 24'h07000F));
    plan.push_back(pixel_row(24'hFFFFFF, 1'b1, 24'hFFFFFF));
    plan.push_back(cfg_row(CFG_CONTRAST_GAIN, 11'd26));
    plan.push_back(pixel_row(24'hFF800A, 1'b0, 24'h0));
    plan.push_back(cfg_row(CFG_CONTRAST_GAIN, 11'd1280));
    plan.push_back(pixel_row(24'h333401, 1'b1, 24'hFFFF05));
    // writes to unused indexes must not disturb anything
    plan.push_back(cfg_row(CFG_SPARE_LO, 11'h7FF));
    plan.push_back(cfg_row(CFG_SPARE_HI, 11'h555));
    plan.push_back(pixel_row(24'h102030, 1'b1, 24'h50A0F0));
    plan.push_back(cfg_row(CFG_MONO_ENABLE, 11'd1));
    plan.push_back(cfg_row(CFG_INVERT_ENABLE, 11'd1));
    plan.push_back(cfg_row(CFG_BRIGHTNESS_OFFSET, 11'h1EC));
    plan.push_back(cfg_row(CFG_CONTRAST_GAIN, 11'd300));
    plan.push_back(pixel_row(24'hC86432, 1'b0, 24'h0));
    plan.push_back(pixel_row(24'h000000, 1'b0, 24'h0));
    plan.push_back(pixel_row(24'hFFFFFF, 1'b0, 24'h0));
    plan.push_back(cfg_row(CFG_MONO_ENABLE, 11'd0));
    plan.push_back(cfg_row(CFG_BRIGHTNESS_OFFSET, 11'h0FF));
    plan.push_back(cfg_row(CFG_CONTRAST_GAIN, 11'd1280));
    plan.push_back(pixel_row(24'h000000, 1'b1, 24'hFFFFFF));

    was_pixel = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (was_pixel) begin
          drain_pipe();
        end
        write_reg(plan[i].idx, plan[i].val);
        was_pixel = 1'b0;
      end else begin
        send_pixel(plan[i].px, plan[i].typed, plan[i].want);
        was_pixel = 1'b1;
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_pipe();
      no_idle = (phase % 4 == 3);
      write_reg(CFG_MONO_ENABLE, 11'($urandom));
      write_reg(CFG_INVERT_ENABLE, 11'($urandom));
      if ($urandom_range(0, 3) == 0) begin
        pick = bright_marks[$urandom_range(0, 3)];
      end else begin
        pick = 11'($urandom);
      end
      write_reg(CFG_BRIGHTNESS_OFFSET, pick);
      case ($urandom_range(0, 4))
        0: pick = gain_marks[$urandom_range(0, 3)];
        1: pick = 11'($urandom);
        default: pick = 11'($urandom_range(26, 1280));
      endcase
      write_reg(CFG_CONTRAST_GAIN, pick);
      if ($urandom_range(0, 2) == 0) begin
        write_reg(3'(CFG_SPARE_LO + $urandom_range(0, 3)), 11'($urandom));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        bits = 24'($urandom);
        if ($urandom_range(0, 7) == 0) begin
          bits = {{8{bits[0]}}, {8{bits[1]}}, {8{bits[2]}}};
        end
        px = rpa_in_t'(bits);
        send_pixel(px, 1'b0, '0);
      end
    end

    drain_pipe();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
